@@ design/rotated_direction_cosines_fov_core_assert.svh @@
// ----------------------------------------------------------------------------
// rotated direction cosines fov core assertion macros
// shared property forms used by the checker
// ----------------------------------------------------------------------------
`ifndef ROTATED_DIRECTION_COSINES_FOV_CORE_ASSERT_SVH
`define ROTATED_DIRECTION_COSINES_FOV_CORE_ASSERT_SVH

// same-cycle implication
`define RDC_ASSERT_IMP(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RDC_ASSERT_NXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// types, constants and arithmetic helpers of the rotated direction cosines core
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int NLANE  = 5;
    localparam int CSTEPS = 30;
    localparam int XW     = 34;
    localparam int ZW     = 33;
    localparam int CW     = 32;
    localparam int DW     = 34;

    localparam int LANE_THETA = 0;
    localparam int LANE_PHI   = 1;
    localparam int LANE_ALPHA = 2;
    localparam int LANE_BETA  = 3;
    localparam int LANE_GAMMA = 4;

    localparam logic [2:0] REG_ALPHA = 3'd0;
    localparam logic [2:0] REG_BETA  = 3'd1;
    localparam logic [2:0] REG_GAMMA = 3'd2;
    localparam logic [2:0] REG_FOV_L = 3'd3;
    localparam logic [2:0] REG_FOV_M = 3'd4;

    localparam logic [15:0] FOV_RESET = 16'd32768;

    localparam logic signed [XW-1:0]   CORDIC_GAIN = XW'(64'sd652032874);
    localparam logic signed [ZW-1:0]   Z_OFFSET    = ZW'(64'sd536870912);
    localparam logic signed [2*DW-1:0] MUL_RND     = (2*DW)'(64'sd536870912);
    localparam logic signed [DW-1:0]   Q15_RND     = DW'(64'sd16384);

    typedef logic signed [CW-1:0] trig_t;
    typedef logic signed [DW-1:0] fix_t;

    typedef struct packed {
        logic en;
        logic vld;
    } pipe_ctl_t;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({{(ZW-32){1'b0}}, v});
    endfunction

    function automatic fix_t mul30(input fix_t a, input fix_t b);
        logic signed [2*DW-1:0] p;
        p = a * b;
        p = p + MUL_RND;
        return DW'(p >>> 30);
    endfunction

    function automatic logic signed [15:0] to_q15(input fix_t v);
        logic signed [DW-1:0] s;
        logic signed [DW-16:0] r;
        s = v + Q15_RND;
        r = (DW-15)'(s >>> 15);
        if (r > (DW-15)'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -(DW-15)'(32768)) begin
            return 16'sh8000;
        end
        return 16'(r);
    endfunction

endpackage

@@ design/rdc_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_cordic
// pipelined rotation-mode cordic, one stage per step, for all angle lanes
// ----------------------------------------------------------------------------
module rdc_cordic (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rdc_pkg::pipe_ctl_t                     ctl,
    input  logic [rdc_pkg::NLANE-1:0][15:0]        ang,
    output logic                                   out_vld,
    output logic [rdc_pkg::NLANE-1:0][rdc_pkg::CW-1:0] cos_o,
    output logic [rdc_pkg::NLANE-1:0][rdc_pkg::CW-1:0] sin_o
);
    import rdc_pkg::*;

    logic signed [XW-1:0] x_reg  [CSTEPS+1][NLANE];
    logic signed [XW-1:0] y_reg  [CSTEPS+1][NLANE];
    logic signed [ZW-1:0] z_reg  [CSTEPS+1][NLANE];
    logic [1:0]           q_reg  [CSTEPS+1][NLANE];
    logic signed [XW-1:0] x_next [CSTEPS+1][NLANE];
    logic signed [XW-1:0] y_next [CSTEPS+1][NLANE];
    logic signed [ZW-1:0] z_next [CSTEPS+1][NLANE];
    logic [1:0]           q_next [CSTEPS+1][NLANE];
    logic [CSTEPS:0]      vld_reg;
    logic                 out_vld_reg;
    logic [NLANE-1:0][CW-1:0] cos_reg;
    logic [NLANE-1:0][CW-1:0] sin_reg;

    // quadrant split and residual angle
    always_comb begin
        logic [31:0] sh;
        for (int k = 0; k < NLANE; k++) begin
            sh = {ang[k], 16'd0} + 32'h2000_0000;
            q_next[0][k] = sh[31:30];
            x_next[0][k] = CORDIC_GAIN;
            y_next[0][k] = '0;
            z_next[0][k] = $signed({{(ZW-30){1'b0}}, sh[29:0]}) - Z_OFFSET;
        end
    end

    for (genvar gs = 1; gs <= CSTEPS; gs++) begin : g_step
        always_comb begin
            for (int k = 0; k < NLANE; k++) begin
                q_next[gs][k] = q_reg[gs-1][k];
                if (!z_reg[gs-1][k][ZW-1]) begin
                    x_next[gs][k] = x_reg[gs-1][k] - (y_reg[gs-1][k] >>> (gs-1));
                    y_next[gs][k] = y_reg[gs-1][k] + (x_reg[gs-1][k] >>> (gs-1));
                    z_next[gs][k] = z_reg[gs-1][k] - atan_val(gs-1);
                end else begin
                    x_next[gs][k] = x_reg[gs-1][k] + (y_reg[gs-1][k] >>> (gs-1));
                    y_next[gs][k] = y_reg[gs-1][k] - (x_reg[gs-1][k] >>> (gs-1));
                    z_next[gs][k] = z_reg[gs-1][k] + atan_val(gs-1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (ctl.en) begin
            vld_reg     <= {vld_reg[CSTEPS-1:0], ctl.vld};
            out_vld_reg <= vld_reg[CSTEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            for (int s = 0; s <= CSTEPS; s++) begin
                for (int k = 0; k < NLANE; k++) begin
                    x_reg[s][k] <= x_next[s][k];
                    y_reg[s][k] <= y_next[s][k];
                    z_reg[s][k] <= z_next[s][k];
                    q_reg[s][k] <= q_next[s][k];
                end
            end
            // exact quadrant fold
            for (int k = 0; k < NLANE; k++) begin
                case (q_reg[CSTEPS][k])
                    2'd0: begin
                        cos_reg[k] <= CW'(x_reg[CSTEPS][k]);
                        sin_reg[k] <= CW'(y_reg[CSTEPS][k]);
                    end
                    2'd1: begin
                        cos_reg[k] <= CW'(-y_reg[CSTEPS][k]);
                        sin_reg[k] <= CW'(x_reg[CSTEPS][k]);
                    end
                    2'd2: begin
                        cos_reg[k] <= CW'(-x_reg[CSTEPS][k]);
                        sin_reg[k] <= CW'(-y_reg[CSTEPS][k]);
                    end
                    default: begin
                        cos_reg[k] <= CW'(y_reg[CSTEPS][k]);
                        sin_reg[k] <= CW'(-x_reg[CSTEPS][k]);
                    end
                endcase
            end
        end
    end

    assign out_vld = out_vld_reg;
    assign cos_o   = cos_reg;
    assign sin_o   = sin_reg;

endmodule

@@ design/rotated_direction_cosines_fov_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_direction_cosines_fov_core
// direction cosines from two angles, zyz euler rotation and elliptical fov flag
// ----------------------------------------------------------------------------
// channel  | ports      | carries
// input    | s_t*       | tdata: azimuth_angle, polar_angle
// result   | m_t*       | tdata: cos_l, cos_m, cos_n; tuser: in_view
// config   | apb p*     | rot_alpha, rot_beta, rot_gamma, fov_width_l, fov_width_m
//
// one item per cycle while the output is not stalled, through the cordic and then the math stages
// the cordic pipeline of 30 step stages sets the depth
// reset clears all valid bits, angles to 0 and widths to 1.0
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// ----------------------------------------------------------------------------
module rotated_direction_cosines_fov_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // azimuth_angle, polar_angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cos_l, cos_m, cos_n
    output logic [0:0]  m_tuser,   // in_view
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rdc_pkg::*;

    logic        en;
    pipe_ctl_t   cctl;
    logic [NLANE-1:0][15:0]   ang;
    logic                     cv;
    logic [NLANE-1:0][CW-1:0] cos_w;
    logic [NLANE-1:0][CW-1:0] sin_w;

    logic [15:0] rot_alpha_reg, rot_beta_reg, rot_gamma_reg;
    logic [15:0] fov_width_l_reg, fov_width_m_reg;

    fix_t ct, st, cp, sp, ca, sa, cb, sb, cg, sg;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg, m_tvalid_reg;
    fix_t l1_reg, m1_reg, n1_reg, cbcg1_reg, cbsg1_reg, sasg1_reg, sacg1_reg;
    fix_t casg1_reg, cacg1_reg, casb1_reg, sasb1_reg, sbcg1_reg, sbsg1_reg;
    fix_t ca1_reg, sa1_reg, cb1_reg;
    fix_t l2_reg, m2_reg, n2_reg, cacbcg2_reg, cacbsg2_reg, sacbcg2_reg, sacbsg2_reg;
    fix_t sasg2_reg, sacg2_reg, casg2_reg, cacg2_reg, casb2_reg, sasb2_reg;
    fix_t sbcg2_reg, sbsg2_reg, cb2_reg;
    fix_t r00, r01, r10, r11, r20;
    fix_t p3_reg [9];
    logic signed [15:0] ql4_reg, qm4_reg, qn4_reg, ql5_reg, qm5_reg, qn5_reg;
    logic signed [15:0] ql6_reg, qm6_reg, qn6_reg;
    logic [31:0] lsq5_reg, msq5_reg, wl5_reg, wm5_reg;
    logic        npos5_reg, npos6_reg;
    logic [63:0] a6_reg, b6_reg, c6_reg;
    logic [47:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        wr;

    // configuration port
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_alpha_reg   <= '0;
            rot_beta_reg    <= '0;
            rot_gamma_reg   <= '0;
            fov_width_l_reg <= FOV_RESET;
            fov_width_m_reg <= FOV_RESET;
        end else if (wr) begin
            case (paddr[4:2])
                REG_ALPHA: rot_alpha_reg   <= pwdata[15:0];
                REG_BETA:  rot_beta_reg    <= pwdata[15:0];
                REG_GAMMA: rot_gamma_reg   <= pwdata[15:0];
                REG_FOV_L: fov_width_l_reg <= pwdata[15:0];
                REG_FOV_M: fov_width_m_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ALPHA: prdata = {16'd0, rot_alpha_reg};
            REG_BETA:  prdata = {16'd0, rot_beta_reg};
            REG_GAMMA: prdata = {16'd0, rot_gamma_reg};
            REG_FOV_L: prdata = {16'd0, fov_width_l_reg};
            REG_FOV_M: prdata = {16'd0, fov_width_m_reg};
            default:   prdata = '0;
        endcase
    end

    // pipeline advance
    assign en       = m_tready | ~m_tvalid_reg;
    assign s_tready = en;
    assign cctl.en  = en;
    assign cctl.vld = s_tvalid;

    always_comb begin
        ang             = '0;
        ang[LANE_THETA] = s_tdata[15:0];
        ang[LANE_PHI]   = s_tdata[31:16];
        ang[LANE_ALPHA] = rot_alpha_reg;
        ang[LANE_BETA]  = rot_beta_reg;
        ang[LANE_GAMMA] = rot_gamma_reg;
    end

    rdc_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (cctl),
        .ang     (ang),
        .out_vld (cv),
        .cos_o   (cos_w),
        .sin_o   (sin_w)
    );

    assign ct = DW'($signed(cos_w[LANE_THETA]));
    assign st = DW'($signed(sin_w[LANE_THETA]));
    assign cp = DW'($signed(cos_w[LANE_PHI]));
    assign sp = DW'($signed(sin_w[LANE_PHI]));
    assign ca = DW'($signed(cos_w[LANE_ALPHA]));
    assign sa = DW'($signed(sin_w[LANE_ALPHA]));
    assign cb = DW'($signed(cos_w[LANE_BETA]));
    assign sb = DW'($signed(sin_w[LANE_BETA]));
    assign cg = DW'($signed(cos_w[LANE_GAMMA]));
    assign sg = DW'($signed(sin_w[LANE_GAMMA]));

    // rotation coefficients
    assign r00 = cacbcg2_reg - sasg2_reg;
    assign r01 = -cacbsg2_reg - sacg2_reg;
    assign r10 = sacbcg2_reg + casg2_reg;
    assign r11 = -sacbsg2_reg + cacg2_reg;
    assign r20 = -sbcg2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg     <= 1'b0;
            vld2_reg     <= 1'b0;
            vld3_reg     <= 1'b0;
            vld4_reg     <= 1'b0;
            vld5_reg     <= 1'b0;
            vld6_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld1_reg     <= cv;
            vld2_reg     <= vld1_reg;
            vld3_reg     <= vld2_reg;
            vld4_reg     <= vld3_reg;
            vld5_reg     <= vld4_reg;
            vld6_reg     <= vld5_reg;
            m_tvalid_reg <= vld6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l1_reg    <= mul30(ct, sp);
            m1_reg    <= mul30(st, sp);
            n1_reg    <= cp;
            cbcg1_reg <= mul30(cb, cg);
            cbsg1_reg <= mul30(cb, sg);
            sasg1_reg <= mul30(sa, sg);
            sacg1_reg <= mul30(sa, cg);
            casg1_reg <= mul30(ca, sg);
            cacg1_reg <= mul30(ca, cg);
            casb1_reg <= mul30(ca, sb);
            sasb1_reg <= mul30(sa, sb);
            sbcg1_reg <= mul30(sb, cg);
            sbsg1_reg <= mul30(sb, sg);
            ca1_reg   <= ca;
            sa1_reg   <= sa;
            cb1_reg   <= cb;

            l2_reg      <= l1_reg;
            m2_reg      <= m1_reg;
            n2_reg      <= n1_reg;
            cacbcg2_reg <= mul30(ca1_reg, cbcg1_reg);
            cacbsg2_reg <= mul30(ca1_reg, cbsg1_reg);
            sacbcg2_reg <= mul30(sa1_reg, cbcg1_reg);
            sacbsg2_reg <= mul30(sa1_reg, cbsg1_reg);
            sasg2_reg   <= sasg1_reg;
            sacg2_reg   <= sacg1_reg;
            casg2_reg   <= casg1_reg;
            cacg2_reg   <= cacg1_reg;
            casb2_reg   <= casb1_reg;
            sasb2_reg   <= sasb1_reg;
            sbcg2_reg   <= sbcg1_reg;
            sbsg2_reg   <= sbsg1_reg;
            cb2_reg     <= cb1_reg;

            p3_reg[0] <= mul30(l2_reg, r00);
            p3_reg[1] <= mul30(m2_reg, r01);
            p3_reg[2] <= mul30(n2_reg, casb2_reg);
            p3_reg[3] <= mul30(l2_reg, r10);
            p3_reg[4] <= mul30(m2_reg, r11);
            p3_reg[5] <= mul30(n2_reg, sasb2_reg);
            p3_reg[6] <= mul30(l2_reg, r20);
            p3_reg[7] <= mul30(m2_reg, sbsg2_reg);
            p3_reg[8] <= mul30(n2_reg, cb2_reg);

            ql4_reg <= to_q15(p3_reg[0] + p3_reg[1] + p3_reg[2]);
            qm4_reg <= to_q15(p3_reg[3] + p3_reg[4] + p3_reg[5]);
            qn4_reg <= to_q15(p3_reg[6] + p3_reg[7] + p3_reg[8]);

            lsq5_reg  <= 32'(ql4_reg * ql4_reg);
            msq5_reg  <= 32'(qm4_reg * qm4_reg);
            wl5_reg   <= 32'(fov_width_l_reg) * 32'(fov_width_l_reg);
            wm5_reg   <= 32'(fov_width_m_reg) * 32'(fov_width_m_reg);
            npos5_reg <= (qn4_reg > 16'sd0);
            ql5_reg   <= ql4_reg;
            qm5_reg   <= qm4_reg;
            qn5_reg   <= qn4_reg;

            a6_reg    <= 64'(lsq5_reg) * 64'(wm5_reg);
            b6_reg    <= 64'(msq5_reg) * 64'(wl5_reg);
            c6_reg    <= 64'(wl5_reg) * 64'(wm5_reg);
            npos6_reg <= npos5_reg;
            ql6_reg   <= ql5_reg;
            qm6_reg   <= qm5_reg;
            qn6_reg   <= qn5_reg;

            m_tdata_reg <= {qn6_reg, qm6_reg, ql6_reg};
            m_tuser_reg <= ((a6_reg + b6_reg) < c6_reg) && npos6_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ design/rdc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_checker
// port-level checks of the rotated direction cosines core
// ----------------------------------------------------------------------------
`include "rotated_direction_cosines_fov_core_assert.svh"

module rdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `RDC_ASSERT_NXT(a_stall_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result item changed while stalled")
    `RDC_ASSERT_IMP(a_stall_blocks_input, aclk, !aresetn, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `RDC_ASSERT_IMP(a_view_needs_front, aclk, !aresetn, m_tvalid && m_tuser[0], !m_tdata[47] && (m_tdata[47:32] != 16'd0), "in_view set with cos_n not positive")
    `RDC_ASSERT_NXT(a_reset_clears, aclk, 1'b0, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind rotated_direction_cosines_fov_core rdc_checker u_rdc_checker (.*);
